// ----- sv/incremental_ddt_apn_checker_macros.svh -----
// Assertion macros for the incremental DDT APN checker.
// Included by the top level; no other dependencies.
`ifndef INCREMENTAL_DDT_APN_CHECKER_MACROS_SVH
`define INCREMENTAL_DDT_APN_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IDAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IDAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/idac_pkg.sv -----
// Shared types and constants of the incremental DDT APN checker.
// No dependencies; imported by the count store, the top level and the bench.
package idac_pkg;

    // fixed field widths of the stream beats
    localparam int FIELD_W     = 7;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 8;
    localparam int TUSER_IN_W  = 2;

    // pair count per table entry, saturating
    localparam int CNT_W = 2;
    typedef logic [CNT_W-1:0] t_count;
    localparam t_count COUNT_MAX = 2'd3;

    // item kinds carried in tuser
    typedef enum logic [TUSER_IN_W-1:0] {
        KIND_SET    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

endpackage

// ----- sv/idac_value_store.sv -----
// S-box value memory: one write port, one registered read port.
// No package dependencies.
module idac_value_store #(
    parameter int DIM_BITS = 7
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [DIM_BITS-1:0] i_waddr,
    input  logic [DIM_BITS-1:0] i_wdata,
    input  logic [DIM_BITS-1:0] i_raddr,
    output logic [DIM_BITS-1:0] o_rdata
);
    localparam int SIZE = 1 << DIM_BITS;

    logic [DIM_BITS-1:0] mem [SIZE];
    logic [DIM_BITS-1:0] r_rdata;

    // write and synchronous read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/idac_count_store.sv -----
// Pair-count memory of the partial difference table, indexed {difference, out diff}.
// Depends on idac_pkg for the count type.
module idac_count_store #(
    parameter int DIM_BITS = 7
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [2*DIM_BITS-1:0]   i_waddr,
    input  idac_pkg::t_count        i_wdata,
    input  logic [2*DIM_BITS-1:0]   i_raddr,
    output idac_pkg::t_count        o_rdata
);
    import idac_pkg::*;

    localparam int DEPTH = 1 << (2 * DIM_BITS);

    t_count mem [DEPTH];
    t_count r_rdata;

    // write and synchronous read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/incremental_ddt_apn_checker.sv -----
// Top level of the incremental DDT APN checker: control, walk pipeline, output register.
// Depends on idac_pkg, idac_value_store, idac_count_store and the macros header.
//
// Usage:
//   Input beats on s_axis carry one item each: tuser holds the kind (set, remove,
//   clear), tdata holds position and value. Output beats on m_axis carry one
//   result per item: tuser is the still-APN flag, tdata the failing difference.
//   One item is in work at a time; s_axis_tready is high only while idle.
//   Set: the walk issues one even-weight difference per cycle through a three-
//   stage read-modify-write pipe (value read, count read, count write); it ends
//   early when a count rises above one, and the block returns to idle as the
//   result is loaded into the output register. Remove first fetches the stored
//   value in a load state, and its walk ends early when a count falls to one.
//   Clear and reset sweep all 2^(2*DIM_BITS) entries of the pair-count memory
//   one entry per cycle, with s_axis_tready low.
//   Other items go straight to the done state.
//   The result lands in an output register; a new item is taken while it waits.
//   If the receiver stalls and the next result is ready, the block holds it
//   internally and keeps s_axis_tready low until the register frees up.
`include "incremental_ddt_apn_checker_macros.svh"

module incremental_ddt_apn_checker #(
    parameter int DIM_BITS = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beats
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [idac_pkg::TDATA_IN_W-1:0]    s_axis_tdata,  // position[6:0], value[13:7]
    input  logic [idac_pkg::TUSER_IN_W-1:0]    s_axis_tuser,  // kind[1:0]
    // result beats
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [idac_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,  // failing_difference[6:0]
    output logic [0:0]                         m_axis_tuser   // still_apn[0]
);
    import idac_pkg::*;

    localparam int SIZE    = 1 << DIM_BITS;
    localparam int K_W     = DIM_BITS - 1;
    localparam int CADDR_W = 2 * DIM_BITS;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state                r_state;
    logic [SIZE-1:0]       r_defined;
    logic [DIM_BITS-1:0]   r_c;
    logic [DIM_BITS-1:0]   r_vc;
    logic                  r_is_rem;
    logic [K_W-1:0]        r_k;
    logic                  r_issue_done;
    logic                  r_s1_vld;
    logic [DIM_BITS-1:0]   r_s1_a;
    logic                  r_s2_vld;
    logic [DIM_BITS-1:0]   r_s2_a;
    logic [DIM_BITS-1:0]   r_s2_d;
    logic [CADDR_W-1:0]    r_clr_addr;
    logic                  r_clr_reply;
    logic                  r_res_ok;
    logic [FIELD_W-1:0]    r_res_diff;
    logic                  r_out_vld;
    logic                  r_out_ok;
    logic [FIELD_W-1:0]    r_out_diff;

    logic                  in_accept;
    t_kind                 in_kind;
    logic [DIM_BITS-1:0]   in_c;
    logic [DIM_BITS-1:0]   in_v;
    logic [DIM_BITS-1:0]   issue_a;
    logic [DIM_BITS-1:0]   issue_q;
    logic                  issue_go;
    logic [DIM_BITS-1:0]   vq;
    logic [DIM_BITS-1:0]   s1_d;
    t_count                cnt;
    t_count                n_cnt;
    logic                  stop;
    logic                  walk_end;
    logic                  out_free;

    logic                  val_we;
    logic [DIM_BITS-1:0]   val_raddr;
    logic [DIM_BITS-1:0]   val_rdata_w;
    logic                  cnt_we;
    logic [CADDR_W-1:0]    cnt_waddr;
    t_count                cnt_wdata;
    logic [CADDR_W-1:0]    cnt_raddr;
    t_count                cnt_rdata_w;

    // input decode
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_kind       = t_kind'(s_axis_tuser);
    assign in_c          = DIM_BITS'(s_axis_tdata[FIELD_W-1:0]);
    assign in_v          = DIM_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);

    // issue stage: k-th nonzero even-weight difference is {k, parity(k)}
    assign issue_a  = {r_k, ^r_k};
    assign issue_q  = r_c ^ issue_a;
    assign issue_go = (r_state == ST_WALK) && !r_issue_done && !stop;

    // stage 1: partner value arrives, form output difference
    assign vq   = val_rdata_w;
    assign s1_d = r_vc ^ vq;

    // stage 2: count arrives, modify with saturation and test for the stop
    assign cnt = cnt_rdata_w;
    always_comb begin
        if (r_is_rem) begin
            n_cnt = (cnt == '0) ? cnt : cnt - 1'b1;
        end else begin
            n_cnt = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
        end
    end
    assign stop = r_s2_vld && (r_is_rem ? (n_cnt == t_count'(1)) : (n_cnt > t_count'(1)));

    assign walk_end = (r_state == ST_WALK) &&
                      (stop || (r_issue_done && !r_s1_vld && !r_s2_vld));
    assign out_free = !r_out_vld || m_axis_tready;

    // memory ports
    assign val_we    = in_accept && (in_kind == KIND_SET);
    assign val_raddr = (r_state == ST_IDLE) ? in_c : issue_q;
    assign cnt_raddr = {r_s1_a, s1_d};
    assign cnt_we    = (r_state == ST_CLEAR) || r_s2_vld;
    assign cnt_waddr = (r_state == ST_CLEAR) ? r_clr_addr : {r_s2_a, r_s2_d};
    assign cnt_wdata = (r_state == ST_CLEAR) ? t_count'(0) : n_cnt;

    idac_value_store #(.DIM_BITS(DIM_BITS)) u_value (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (in_c),
        .i_wdata (in_v),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata_w)
    );

    idac_count_store #(.DIM_BITS(DIM_BITS)) u_count (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata_w)
    );

    // walk pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_a <= issue_a;
        r_s2_a <= r_s1_a;
        r_s2_d <= s1_d;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_defined    <= '0;
            r_clr_addr   <= '0;
            r_clr_reply  <= 1'b0;
            r_issue_done <= 1'b0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
        end else begin
            // pipeline valids; a stop squashes the younger read
            r_s1_vld <= issue_go && r_defined[issue_q];
            r_s2_vld <= r_s1_vld && !stop;

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_res_ok   <= 1'b1;
                        r_res_diff <= '0;
                        r_state    <= r_clr_reply ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_c          <= in_c;
                        r_vc         <= in_v;
                        r_k          <= K_W'(1);
                        r_issue_done <= 1'b0;
                        r_res_ok     <= 1'b1;
                        r_res_diff   <= '0;
                        unique case (in_kind)
                            KIND_SET: begin
                                r_is_rem        <= 1'b0;
                                r_defined[in_c] <= 1'b1;
                                r_state         <= ST_WALK;
                            end
                            KIND_REMOVE: begin
                                r_is_rem <= 1'b1;
                                r_state  <= r_defined[in_c] ? ST_LOAD : ST_DONE;
                            end
                            KIND_CLEAR: begin
                                r_defined   <= '0;
                                r_clr_addr  <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= ST_CLEAR;
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    // stored value of the point being removed
                    r_vc    <= val_rdata_w;
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (issue_go) begin
                        r_k <= r_k + 1'b1;
                        if (r_k == '1) begin
                            r_issue_done <= 1'b1;
                        end
                    end
                    if (walk_end) begin
                        if (r_is_rem) begin
                            r_defined[r_c] <= 1'b0;
                        end else if (stop) begin
                            r_res_ok   <= 1'b0;
                            r_res_diff <= FIELD_W'(r_s2_a);
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register: load a finished result, else drain on a taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_vld  <= 1'b1;
            r_out_ok   <= r_res_ok;
            r_out_diff <= r_res_diff;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result beat
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDATA_OUT_W'(r_out_diff);
    assign m_axis_tuser  = r_out_ok;

    // checks
    `IDAC_ASSERT_IMP(a_idle_pipe_empty, i_clk, i_rst_n, s_axis_tready, !r_s1_vld && !r_s2_vld, "walk pipeline busy while taking input")
    `IDAC_ASSERT_IMP(a_rmw_in_walk, i_clk, i_rst_n, r_s2_vld, r_state == ST_WALK, "count write outside a walk")
    `IDAC_ASSERT_IMP(a_fail_nonzero, i_clk, i_rst_n, r_out_vld && !r_out_ok, r_out_diff != '0 || DIM_BITS > FIELD_W, "failing result without a difference")
    `IDAC_ASSERT_NXT(a_clear_empties, i_clk, i_rst_n, in_accept && in_kind == KIND_CLEAR, r_defined == '0 && r_state == ST_CLEAR, "clear left defined points")

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for the incremental DDT APN checker: directed items, then
// search-like random runs of set/remove (some unused kinds, a clear per run) with a pair-count predictor.
// Depends on idac_pkg and the incremental_ddt_apn_checker top level.
module testbench;
    import idac_pkg::*;

    localparam int          DIM         = 7;
    localparam int          SIZE        = 1 << DIM;
    localparam bit [1:0]    KIND_UNUSED = 2'd3;
    localparam int          EPISODES    = 6;
    localparam int          EPISODE_LEN = 240;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct packed {
        bit [1:0]         kind;
        bit [FIELD_W-1:0] pos;
        bit [FIELD_W-1:0] val;
    } t_item;

    typedef struct {
        bit               apn;
        bit [FIELD_W-1:0] diff;
    } t_verdict;

    // partial S-box, its pair counts, and the verdicts still owed by the block
    class ddt_tracker;
        bit [FIELD_W-1:0] pos_value [SIZE];
        bit               pos_used  [SIZE];
        bit [CNT_W-1:0]   pair_cnt  [SIZE][SIZE];
        t_verdict         pending[$];
        int               mismatches;

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // apply one accepted item; returns the difference that overflowed, or 0
        function bit [FIELD_W-1:0] take_item(bit [1:0] kind, bit [FIELD_W-1:0] pos,
                                             bit [FIELD_W-1:0] val);
            bit [FIELD_W-1:0] fail;
            bit [FIELD_W-1:0] diff;
            bit [FIELD_W-1:0] partner;
            bit [FIELD_W-1:0] outd;
            bit               stop;
            t_verdict         vd;
            int               a;
            fail = '0;
            stop = 1'b0;
            case (kind)
                KIND_SET: begin
                    pos_value[pos] = val;
                    pos_used[pos]  = 1'b1;
                    // walk even-weight differences, stop on the first double pair
                    for (a = 1; a < SIZE && fail == 0; a++) begin
                        diff    = a[FIELD_W-1:0];
                        partner = pos ^ diff;
                        if (!(^diff) && pos_used[partner]) begin
                            outd = val ^ pos_value[partner];
                            if (pair_cnt[diff][outd] != COUNT_MAX)
                                pair_cnt[diff][outd] = pair_cnt[diff][outd] + 1'b1;
                            if (pair_cnt[diff][outd] > 1)
                                fail = diff;
                        end
                    end
                end
                KIND_REMOVE: begin
                    if (pos_used[pos]) begin
                        // same walk, undo until the entry falls back to one pair
                        for (a = 1; a < SIZE && !stop; a++) begin
                            diff    = a[FIELD_W-1:0];
                            partner = pos ^ diff;
                            if (!(^diff) && pos_used[partner]) begin
                                outd = pos_value[pos] ^ pos_value[partner];
                                if (pair_cnt[diff][outd] != 0)
                                    pair_cnt[diff][outd] = pair_cnt[diff][outd] - 1'b1;
                                if (pair_cnt[diff][outd] == 1)
                                    stop = 1'b1;
                            end
                        end
                        pos_used[pos]  = 1'b0;
                        pos_value[pos] = '0;
                    end
                end
                KIND_CLEAR: begin
                    foreach (pos_used[i]) begin
                        pos_used[i]  = 1'b0;
                        pos_value[i] = '0;
                    end
                    foreach (pair_cnt[i, j])
                        pair_cnt[i][j] = '0;
                end
                default: ;
            endcase
            vd.apn  = (fail == 0);
            vd.diff = fail;
            pending.push_back(vd);
            return fail;
        endfunction

        // compare one result beat against the oldest owed verdict
        task check_verdict(bit apn, bit [FIELD_W-1:0] diff);
            t_verdict want;
            if (pending.size() == 0) begin
                report($sformatf("result apn=%0d diff=%0d with no item pending", apn, diff));
                return;
            end
            want = pending.pop_front();
            if (apn != want.apn)
                report($sformatf("still_apn %0d, expected %0d", apn, want.apn));
            if (diff != want.diff)
                report($sformatf("failing_difference %0d, expected %0d", diff, want.diff));
        endtask
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;   // position[6:0], value[13:7]
    logic [TUSER_IN_W-1:0]  s_axis_tuser  = '0;   // kind[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;         // failing_difference[6:0]
    logic [0:0]             m_axis_tuser;         // still_apn[0]

    ddt_tracker  sb;
    bit          calm        = 1'b0;
    int unsigned cycle_count = 0;
    int          stall_left  = 0;

    // hand-built items: ignored kinds, a double pair, saturation both ways, extremes
    t_item directed_items [25] = '{
        '{KIND_REMOVE, 7'd5,   7'd0},    // remove of an undefined point
        '{KIND_UNUSED, 7'd127, 7'd127},
        '{KIND_SET,    7'd0,   7'd0},
        '{KIND_SET,    7'd3,   7'd1},
        '{KIND_SET,    7'd4,   7'd4},
        '{KIND_SET,    7'd97,  7'd50},
        '{KIND_SET,    7'd7,   7'd5},    // double pair at difference 3
        '{KIND_REMOVE, 7'd97,  7'd0},    // walk passes an uncounted pair: stays at zero
        '{KIND_REMOVE, 7'd7,   7'd0},
        '{KIND_SET,    7'd7,   7'd5},
        '{KIND_SET,    7'd7,   7'd5},    // overwrite, count climbs to three
        '{KIND_SET,    7'd7,   7'd5},    // count held at three
        '{KIND_REMOVE, 7'd7,   7'd0},
        '{KIND_SET,    7'd127, 7'd127},
        '{KIND_SET,    7'd124, 7'd0},
        '{KIND_REMOVE, 7'd127, 7'd0},
        '{KIND_REMOVE, 7'd127, 7'd0},
        '{KIND_SET,    7'd85,  7'd42},
        '{KIND_SET,    7'd42,  7'd85},
        '{KIND_CLEAR,  7'd0,   7'd0},
        '{KIND_SET,    7'd0,   7'd0},    // table must be empty again
        '{KIND_SET,    7'd3,   7'd1},
        '{KIND_SET,    7'd4,   7'd4},
        '{KIND_SET,    7'd7,   7'd5},
        '{KIND_UNUSED, 7'd0,   7'd0}
    };

    incremental_ddt_apn_checker #(.DIM_BITS(DIM)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // present one beat and hold it until accepted, then predict its verdict
    task automatic send_item(input bit [1:0] kind, input bit [FIELD_W-1:0] pos,
                             input bit [FIELD_W-1:0] val, output bit [FIELD_W-1:0] fail);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, val, pos};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        fail = sb.take_item(kind, pos, val);
    endtask

    // result side: check each beat, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_verdict(m_axis_tuser[0], m_axis_tdata[FIELD_W-1:0]);
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        bit [FIELD_W-1:0] fail;
        bit [FIELD_W-1:0] p;
        bit [FIELD_W-1:0] v;
        bit [FIELD_W-1:0] last_pos;
        bit [1:0]         k;
        bit               open_fail;
        bit               counted;
        int               n;
        int               raw;
        int               r;
        int               t;
        sb        = new();
        open_fail = 1'b0;
        last_pos  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_items[i])
            send_item(directed_items[i].kind, directed_items[i].pos,
                      directed_items[i].val, fail);

        // random search runs: extend the partial S-box, back out of failures
        for (int ep = 0; ep < EPISODES; ep++) begin
            n   = 0;
            raw = 0;
            while (n < EPISODE_LEN) begin
                if (raw % 100 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                raw++;
                r = $urandom_range(0, 99);
                p = FIELD_W'($urandom_range(0, SIZE - 1));
                v = FIELD_W'($urandom_range(0, SIZE - 1));
                if (open_fail && r < 85) begin
                    k = KIND_REMOVE;
                    p = last_pos;
                end else if (r < 62) begin
                    k = KIND_SET;
                end else if (r < 90) begin
                    // backtrack or overwrite on a defined point
                    k = (r < 80) ? KIND_REMOVE : KIND_SET;
                    for (t = 0; t < 8 && !sb.pos_used[p]; t++)
                        p = FIELD_W'($urandom_range(0, SIZE - 1));
                end else if (r < 97) begin
                    k = KIND_REMOVE;
                end else begin
                    k = KIND_UNUSED;
                end
                counted = (k != KIND_UNUSED) && !(k == KIND_REMOVE && !sb.pos_used[p]);
                send_item(k, p, v, fail);
                open_fail = (k == KIND_SET) && (fail != 0);
                last_pos  = p;
                if (counted)
                    n++;
            end
            send_item(KIND_CLEAR, FIELD_W'($urandom_range(0, SIZE - 1)),
                      FIELD_W'($urandom_range(0, SIZE - 1)), fail);
            open_fail = 1'b0;
        end

        // drain
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
